// File: hw/rtl/smpq_pkg.sv
// Shared constants, types and control structs of the sorted max priority queue.
`timescale 1ns / 1ps

package smpq_pkg;

  localparam int CAPACITY = 16;
  localparam int AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  typedef logic signed [31:0] value_t;
  typedef logic [CNT_W-1:0]   count_t;

  typedef enum logic {
    CMD_INSERT  = 1'b0,
    CMD_EXTRACT = 1'b1
  } command_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_CMP,
    S_EXT_RD,
    S_EXT_WR,
    S_FIN
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;        // latch request, seed index, status and removed value
    logic rd_prev;     // read entry idx-1
    logic rd_cur;      // read entry idx
    logic wr_val;      // entry idx <= request value
    logic wr_rd_idx;   // entry idx <= read data, idx--
    logic wr_rd_prev;  // entry idx-1 <= read data, idx++
    logic cnt_inc;
    logic cnt_dec;
    logic publish;     // load output register
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic req_ins;     // pending input word is an insert
    logic full;
    logic empty;
    logic idx_zero;
    logic idx_at_cnt;
    logic rd_less;     // read data < request value (signed)
    logic out_free;
  } dp_stat_t;

endpackage

// File: hw/rtl/smpq_req_if.sv
// Request channel: command and value with valid/ready.
`timescale 1ns / 1ps

interface smpq_req_if;
  import smpq_pkg::*;

  logic   valid;
  logic   ready;
  logic   command;
  value_t item_value;

  modport source (output valid, output command, output item_value, input ready);
  modport sink   (input valid, input command, input item_value, output ready);
endinterface

// File: hw/rtl/smpq_rsp_if.sv
// Result channel: status, removed value, top value and count with valid/ready.
`timescale 1ns / 1ps

interface smpq_rsp_if;
  import smpq_pkg::*;

  logic       valid;
  logic       ready;
  logic [1:0] status;
  value_t     removed_value;
  value_t     top_value;
  logic       top_valid;
  logic [4:0] stored_count;

  modport source (output valid, output status, output removed_value, output top_value,
                  output top_valid, output stored_count, input ready);
  modport sink   (input valid, input status, input removed_value, input top_value,
                  input top_valid, input stored_count, output ready);
endinterface

// File: hw/rtl/smpq_ctrl.sv
// Sequencing state machine of the priority queue.
`timescale 1ns / 1ps

module smpq_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  smpq_pkg::dp_stat_t   stat_i,
  output smpq_pkg::ctrl_cmd_t  cmd_o
);
  import smpq_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (stat_i.req_ins) begin
            state_d = stat_i.full ? S_FIN : S_INS_RD;
          end else begin
            state_d = stat_i.empty ? S_FIN : S_EXT_RD;
          end
        end
      end
      S_INS_RD:  state_d = stat_i.idx_zero ? S_FIN : S_INS_CMP;
      S_INS_CMP: state_d = stat_i.rd_less ? S_INS_RD : S_FIN;
      S_EXT_RD:  state_d = stat_i.idx_at_cnt ? S_FIN : S_EXT_WR;
      S_EXT_WR:  state_d = S_EXT_RD;
      S_FIN:     state_d = stat_i.out_free ? S_IDLE : S_FIN;
      default:   state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      S_INS_RD: begin
        if (stat_i.idx_zero) begin
          cmd_o.wr_val  = 1'b1;
          cmd_o.cnt_inc = 1'b1;
        end else begin
          cmd_o.rd_prev = 1'b1;
        end
      end
      S_INS_CMP: begin
        if (stat_i.rd_less) begin
          cmd_o.wr_rd_idx = 1'b1;
        end else begin
          cmd_o.wr_val  = 1'b1;
          cmd_o.cnt_inc = 1'b1;
        end
      end
      S_EXT_RD: begin
        if (stat_i.idx_at_cnt) begin
          cmd_o.cnt_dec = 1'b1;
        end else begin
          cmd_o.rd_cur = 1'b1;
        end
      end
      S_EXT_WR: cmd_o.wr_rd_prev = 1'b1;
      S_FIN:    cmd_o.publish    = stat_i.out_free;
      default:  cmd_o = '0;
    endcase
  end

endmodule

// File: hw/rtl/smpq_datapath.sv
// Entry memory, count, top register and output register of the priority queue.
`timescale 1ns / 1ps

module smpq_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_command_i,
  input  smpq_pkg::value_t     in_value_i,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output logic [1:0]           out_status_o,
  output smpq_pkg::value_t     out_removed_o,
  output smpq_pkg::value_t     out_top_o,
  output logic                 out_top_valid_o,
  output logic [4:0]           out_count_o,
  input  smpq_pkg::ctrl_cmd_t  cmd_i,
  output smpq_pkg::dp_stat_t   stat_o
);
  import smpq_pkg::*;

  value_t  mem_q [CAPACITY];
  value_t  rdata_q;

  value_t  val_q;
  count_t  idx_q, idx_d;
  count_t  count_q, count_d;
  value_t  top_q, top_d;
  status_e status_q, status_d;
  value_t  removed_q, removed_d;

  logic    out_valid_q, out_valid_d;
  status_e out_status_q;
  value_t  out_removed_q, out_top_q;
  logic    out_top_valid_q;
  count_t  out_count_q;

  count_t  idx_prev;
  logic    full, empty, req_ins;
  logic    wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  value_t  wr_data;

  assign idx_prev = idx_q - count_t'(1);
  assign full     = (count_q == count_t'(CAPACITY));
  assign empty    = (count_q == '0);
  assign req_ins  = (in_command_i == CMD_INSERT);

  assign stat_o.req_ins    = req_ins;
  assign stat_o.full       = full;
  assign stat_o.empty      = empty;
  assign stat_o.idx_zero   = (idx_q == '0);
  assign stat_o.idx_at_cnt = (idx_q == count_q);
  assign stat_o.rd_less    = (rdata_q < val_q);
  assign stat_o.out_free   = !out_valid_q || out_ready_i;

  // single write port, single registered read port
  always_comb begin
    wr_en   = cmd_i.wr_val || cmd_i.wr_rd_idx || cmd_i.wr_rd_prev;
    wr_addr = cmd_i.wr_rd_prev ? idx_prev[AW-1:0] : idx_q[AW-1:0];
    wr_data = cmd_i.wr_val ? val_q : rdata_q;
    rd_en   = cmd_i.rd_prev || cmd_i.rd_cur;
    rd_addr = cmd_i.rd_prev ? idx_prev[AW-1:0] : idx_q[AW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  always_comb begin
    idx_d     = idx_q;
    count_d   = count_q;
    top_d     = top_q;
    status_d  = status_q;
    removed_d = removed_q;
    if (cmd_i.load) begin
      idx_d     = req_ins ? count_q : count_t'(1);
      status_d  = req_ins ? (full ? ST_FULL : ST_OK) : (empty ? ST_EMPTY : ST_OK);
      removed_d = (!req_ins && !empty) ? top_q : '0;
    end
    if (cmd_i.wr_val && (idx_q == '0)) begin
      top_d = val_q;
    end
    if (cmd_i.wr_rd_idx) begin
      idx_d = idx_prev;
    end
    if (cmd_i.wr_rd_prev) begin
      idx_d = idx_q + count_t'(1);
      if (idx_q == count_t'(1)) begin
        top_d = rdata_q;
      end
    end
    if (cmd_i.cnt_inc) begin
      count_d = count_q + count_t'(1);
    end
    if (cmd_i.cnt_dec) begin
      count_d = count_q - count_t'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      val_q <= in_value_i;
    end
    idx_q     <= idx_d;
    top_q     <= top_d;
    status_q  <= status_d;
    removed_q <= removed_d;
    if (cmd_i.publish) begin
      out_status_q    <= status_q;
      out_removed_q   <= removed_q;
      out_top_q       <= empty ? '0 : top_q;
      out_top_valid_q <= !empty;
      out_count_q     <= count_q;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.publish) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_status_o    = out_status_q;
  assign out_removed_o   = out_removed_q;
  assign out_top_o       = out_top_q;
  assign out_top_valid_o = out_top_valid_q;
  assign out_count_o     = 5'(out_count_q);

endmodule

// File: hw/rtl/sorted_max_priority_queue.sv
// Sorted-list max priority queue: top level joining controller and datapath.
// Per word: an insert shifts each entry smaller than the new value down one slot from
// the tail, then writes the value; an extract shifts each entry behind the head up one
// slot; a rejected word goes straight to FIN. An output stall holds FIN; single-port memory sets the rate.
// Result sits in an output register; the next word is taken the cycle after it loads.
// Reset (rst_ni low, async) empties the queue and the output; entries stay uncleared.
`timescale 1ns / 1ps

module sorted_max_priority_queue (
  input  logic        clk_i,
  input  logic        rst_ni,
  smpq_req_if.sink    req_i,
  smpq_rsp_if.source  rsp_o
);
  import smpq_pkg::*;

  // Command/status bundle between the two halves.
  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // Controller: IDLE takes a word, then walks the entry memory one slot per
  // read/write pair (insert walks from the tail, extract from the head),
  // and FIN waits for a free output register.
  smpq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Datapath: entry memory sorted high to low, count, cached maximum and the
  // result register. The cached maximum avoids a second memory read port.
  smpq_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_command_i    (req_i.command),
    .in_value_i      (req_i.item_value),
    .out_ready_i     (rsp_o.ready),
    .out_valid_o     (rsp_o.valid),
    .out_status_o    (rsp_o.status),
    .out_removed_o   (rsp_o.removed_value),
    .out_top_o       (rsp_o.top_value),
    .out_top_valid_o (rsp_o.top_valid),
    .out_count_o     (rsp_o.stored_count),
    .cmd_i           (cmd),
    .stat_o          (stat)
  );

  // A result is only loaded when the output register is free.
  a_publish_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.publish |-> stat.out_free)
    else $error("result loaded over an untaken word");

  // A new word is never taken in the cycle a result is published.
  a_accept_vs_publish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |-> !cmd.publish)
    else $error("accept and publish in the same cycle");

  // Only one memory write per cycle.
  a_one_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.wr_val, cmd.wr_rd_idx, cmd.wr_rd_prev}))
    else $error("conflicting entry writes");

  // Failed requests report no removed value.
  a_fail_removed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && (rsp_o.status != ST_OK)) |-> (rsp_o.removed_value == '0))
    else $error("removed value on failed request");

endmodule

// File: tb/sv/sorted_max_priority_queue_test.sv
// Self-checking testbench for the sorted max priority queue: random and directed words.
`timescale 1ns / 1ps

module sorted_max_priority_queue_test;
  import smpq_pkg::*;

  // Run sizing: about 1850 words in all. The worst case per word is the longest
  // walk in the block plus a sender gap and a result stall; the limit leaves a
  // wide margin over the whole run.
  localparam int RANDOM_WORDS  = 1830;
  localparam int QUIET_WORDS   = 250;   // tail of the run with no idling
  localparam int DRAIN_AT      = 900;   // sender holds off here until results catch up
  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 2 * CAPACITY + 8;
  localparam int MAX_PRINTS    = 40;

  // One result word, as the block presents it.
  typedef struct packed {
    logic [1:0] status;
    value_t     removed;
    value_t     top;
    logic       top_valid;
    logic [4:0] count;
  } queue_result_t;

  // Keeps a sorted copy of the queue and the results still owed by the block.
  class queue_scoreboard;
    value_t        entries[CAPACITY];
    int            held;
    queue_result_t owed_q[$];
    int            errors;
    int            checked;

    function new();
      held    = 0;
      errors  = 0;
      checked = 0;
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    // Apply one accepted request to the sorted copy and queue up its result.
    function void note_request(command_e cmd, value_t val);
      queue_result_t r;
      int            pos;
      r        = '0;
      r.status = ST_OK;
      if (cmd == CMD_INSERT) begin
        if (held >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          // new value goes behind every entry >= it, so ties stay in arrival order
          pos = 0;
          while (pos < held && entries[pos] >= val) pos++;
          for (int i = held; i > pos; i--) entries[i] = entries[i-1];
          entries[pos] = val;
          held++;
        end
      end else if (held == 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.removed = entries[0];
        for (int i = 1; i < held; i++) entries[i-1] = entries[i];
        held--;
      end
      r.top_valid = (held != 0);
      r.top       = (held != 0) ? entries[0] : '0;
      r.count     = 5'(held);
      owed_q.push_back(r);
    endfunction

    task report_mismatch(string msg);
      if (errors < MAX_PRINTS) $display("[%0t] MISMATCH: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(queue_result_t got);
      queue_result_t exp;
      if (owed_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result word status=%0d top=%0d count=%0d",
                                  got.status, got.top, got.count));
      end else begin
        exp = owed_q.pop_front();
        if (got.status !== exp.status)
          report_mismatch($sformatf("word %0d status %0d, want %0d",
                                    checked, got.status, exp.status));
        if (got.removed !== exp.removed)
          report_mismatch($sformatf("word %0d removed_value %0d, want %0d",
                                    checked, got.removed, exp.removed));
        if (got.top !== exp.top)
          report_mismatch($sformatf("word %0d top_value %0d, want %0d",
                                    checked, got.top, exp.top));
        if (got.top_valid !== exp.top_valid)
          report_mismatch($sformatf("word %0d top_valid %0b, want %0b",
                                    checked, got.top_valid, exp.top_valid));
        if (got.count !== exp.count)
          report_mismatch($sformatf("word %0d stored_count %0d, want %0d",
                                    checked, got.count, exp.count));
      end
      checked++;
    endtask
  endclass

  logic clk_i;
  logic rst_ni;

  smpq_req_if req ();
  smpq_rsp_if rsp ();

  sorted_max_priority_queue dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  queue_scoreboard sb;

  // Percent chance of starting an idle burst; shared by sender and receiver.
  // Zero gives stretches with a saturated handshake on both sides.
  int idle_pct;
  int sent;

  // 12 ns clock.
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Hard stop if the block hangs.
  initial begin : watchdog
    int cycles;
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // Result side: check each accepted word, then decide ready for the next edge.
  // Ready drops in bursts while idling is enabled.
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    rsp.ready  = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni === 1'b1 && rsp.valid === 1'b1 && rsp.ready === 1'b1)
        sb.check_result('{status:    rsp.status,
                          removed:   rsp.removed_value,
                          top:       rsp.top_value,
                          top_valid: rsp.top_valid,
                          count:     rsp.stored_count});
      if (stall_left > 0) begin
        stall_left--;
        rsp.ready <= 1'b0;
      end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
        stall_left = $urandom_range(1, 4) - 1;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  // Present one request word and hold it until the block takes it. An optional
  // idle burst comes first; valid is lowered only when a gap is inserted, so
  // back-to-back words never toggle valid within one step.
  task automatic send_word(command_e cmd, value_t val);
    int gap;
    gap = ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req.valid      <= 1'b1;
    req.command    <= cmd;
    req.item_value <= val;
    do @(posedge clk_i); while (req.ready !== 1'b1);
    sb.note_request(cmd, val);
    sent++;
  endtask

  // Sender stays quiet until every owed result has come back.
  task automatic drain_results();
    req.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // Mix of full-range values, a narrow band (lots of ties) and the extremes.
  function automatic value_t random_value();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 4) return value_t'($urandom);
    if (pick < 8) return value_t'(int'($urandom_range(0, 6)) - 3);
    case ($urandom_range(0, 3))
      0:       return 32'sh7fff_ffff;
      1:       return 32'sh8000_0000;
      2:       return 32'sh0000_0000;
      default: return 32'shffff_ffff;
    endcase
  endfunction

  // Directed opener: empty extract, the value extremes, ties, filling up,
  // an insert that hits the full queue, then a few extracts.
  task automatic run_directed();
    send_word(CMD_EXTRACT, 32'sh1234_5678);  // empty queue
    send_word(CMD_INSERT,  32'sh7fff_ffff);
    send_word(CMD_INSERT,  32'sh8000_0000);
    send_word(CMD_INSERT,  32'sh0000_0000);
    send_word(CMD_INSERT,  32'shffff_ffff);
    send_word(CMD_INSERT,  32'sh0000_0001);
    send_word(CMD_INSERT,  32'sh0000_0000);  // tie with a stored zero
    send_word(CMD_INSERT,  32'sh7fff_fffe);
    send_word(CMD_INSERT,  32'sh8000_0001);
    send_word(CMD_INSERT,  32'sh0000_0005);
    send_word(CMD_INSERT,  32'sh0000_0005);
    send_word(CMD_INSERT,  -32'sd5);
    while (sb.held < CAPACITY) send_word(CMD_INSERT, value_t'($urandom));
    send_word(CMD_INSERT, 32'sh7fff_ffff);   // dropped, queue full
    repeat (4) send_word(CMD_EXTRACT, value_t'($urandom));
  endtask

  // Random body in segments. Each segment picks an insert bias so the queue
  // swings between empty and full, and picks whether both sides idle.
  task automatic run_random();
    int       seg_left;
    int       ins_pct;
    int       done;
    command_e cmd;
    seg_left = 0;
    ins_pct  = 50;
    done     = 0;
    while (done < RANDOM_WORDS) begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(10, 60);
        case ($urandom_range(0, 2))
          0:       ins_pct = 15;
          1:       ins_pct = 50;
          default: ins_pct = 85;
        endcase
        idle_pct = ($urandom_range(0, 2) == 0) ? 0 : 25;
      end
      if (done >= RANDOM_WORDS - QUIET_WORDS) idle_pct = 0;
      if (done == DRAIN_AT) drain_results();
      cmd = ($urandom_range(0, 99) < ins_pct) ? CMD_INSERT : CMD_EXTRACT;
      send_word(cmd, random_value());
      seg_left--;
      done++;
    end
  endtask

  // Main sequence: reset once, directed words, random words, drain, verdict.
  initial begin
    sb             = new();
    idle_pct       = 25;
    sent           = 0;
    rst_ni         = 1'b0;
    req.valid      = 1'b0;
    req.command    = CMD_INSERT;
    req.item_value = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();
    run_random();

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (sb.pending() != 0)
      sb.report_mismatch($sformatf("%0d result words never arrived", sb.pending()));

    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: sorted_max_priority_queue.f
hw/rtl/smpq_pkg.sv
hw/rtl/smpq_req_if.sv
hw/rtl/smpq_rsp_if.sv
hw/rtl/smpq_ctrl.sv
hw/rtl/smpq_datapath.sv
hw/rtl/sorted_max_priority_queue.sv
tb/sv/sorted_max_priority_queue_test.sv
